/* src/sgi_pkg.sv */
// shared constants and control types for the sample gap interpolator
`timescale 1ns / 1ps
`default_nettype none

package sgi_pkg;

  // largest gap filled by interpolation, whatever max_gap holds
  localparam int MAX_GAP_LIMIT = 64;

  // register indexes on the configuration port
  localparam logic REG_MAX_GAP        = 1'b0;
  localparam logic REG_RESTART_LENGTH = 1'b1;

  // register reset values
  localparam logic [6:0]  MAX_GAP_RESET        = 7'd10;
  localparam logic [15:0] RESTART_LENGTH_RESET = 16'd100;

  // serial divider runs one quotient bit per cycle over the 33-bit difference
  localparam int DIV_STEPS = 33;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // input transaction taken
    logic div_step;  // one divider iteration
    logic fix;       // floor correction of the step quotient
    logic emit;      // load one interpolated sample into the output
    logic final_ld;  // load the new sample into the output
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic needs_fill;  // input item has a gap to fill
    logic div_last;    // final divider iteration this cycle
    logic emit_last;   // last interpolated sample this cycle
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

`default_nettype wire

/* src/sgi_datapath.sv */
// datapath: config registers, stream state, serial divider, interpolation step
`timescale 1ns / 1ps
`default_nettype none

module sgi_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [15:0]         cfg_data,
  input  wire logic signed [31:0]  sample_value,
  input  wire logic [15:0]         gap,
  input  wire sgi_pkg::cmd_t       cmd,
  output sgi_pkg::sts_t            sts,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic signed [31:0]       out_value,
  output logic                     interpolated,
  output logic                     restart_active,
  output logic                     last_of_run
);

  // configuration
  logic [6:0]  max_gap;
  logic [15:0] restart_length;

  // stream state
  logic signed [31:0] last_sample;
  logic [15:0]        restart_count;
  logic               seen_first;

  // current transaction
  logic signed [31:0] cur_value;
  logic [6:0]         cur_gap;
  logic               act;

  // divider
  logic [32:0] dd;
  logic [6:0]  rem;
  logic        neg;
  logic [5:0]  div_cnt;

  // interpolation accumulator
  logic signed [33:0] q_step;
  logic [7:0]         r_step;
  logic signed [33:0] q_acc;
  logic [7:0]         r_acc;
  logic [6:0]         j;

  logic [6:0]         eff_gap;
  logic               is_restart;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [7:0]         trial;
  logic               qbit;
  logic [8:0]         r_sum;
  logic [8:0]         two_g;
  logic               wrap;
  logic signed [33:0] q_new;
  logic [7:0]         r_new;

  // restart decision on the offered item
  always_comb begin
    eff_gap = (max_gap > 7'(sgi_pkg::MAX_GAP_LIMIT)) ? 7'(sgi_pkg::MAX_GAP_LIMIT) : max_gap;
    is_restart = !seen_first || (gap > {9'd0, eff_gap});
    diff = {sample_value[31], sample_value} - {last_sample[31], last_sample};
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  end

  // divider iteration and accumulator step
  always_comb begin
    trial = {rem, dd[32]};
    qbit = trial >= {1'b0, cur_gap};
    r_sum = {1'b0, r_acc} + {1'b0, r_step};
    two_g = {1'b0, cur_gap, 1'b0};
    wrap = r_sum >= two_g;
    r_new = wrap ? 8'(r_sum - two_g) : r_sum[7:0];
    q_new = q_acc + q_step + {33'd0, wrap};
  end

  // status to the controller
  always_comb begin
    sts.needs_fill = !is_restart && (gap >= 16'd2);
    sts.div_last = div_cnt == 6'(sgi_pkg::DIV_STEPS - 1);
    sts.emit_last = ({1'b0, j} + 8'd2) == {1'b0, cur_gap};
    sts.out_free = !out_valid || out_ready;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap <= sgi_pkg::MAX_GAP_RESET;
      restart_length <= sgi_pkg::RESTART_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sgi_pkg::REG_MAX_GAP:        max_gap <= cfg_data[6:0];
        sgi_pkg::REG_RESTART_LENGTH: restart_length <= cfg_data;
        default:                     max_gap <= max_gap;
      endcase
    end
  end

  // stream state, updated when a transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample <= '0;
      restart_count <= '0;
      seen_first <= 1'b0;
    end else if (cmd.load) begin
      seen_first <= 1'b1;
      last_sample <= sample_value;
      if (is_restart) begin
        restart_count <= 16'd1;
      end else if ((restart_count < restart_length) && (restart_count != 16'hFFFF)) begin
        restart_count <= restart_count + 16'd1;
      end
    end
  end

  // transaction capture, divider and accumulator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_value <= sample_value;
      cur_gap <= gap[6:0];
      act <= is_restart || (restart_count < restart_length);
      dd <= diff_mag;
      neg <= diff[32];
      rem <= '0;
      div_cnt <= '0;
      q_acc <= {{2{last_sample[31]}}, last_sample};
      r_acc <= {1'b0, gap[6:0]};
      j <= '0;
    end
    if (cmd.div_step) begin
      dd <= {dd[31:0], qbit};
      rem <= qbit ? 7'(trial - {1'b0, cur_gap}) : trial[6:0];
      div_cnt <= div_cnt + 6'd1;
    end
    if (cmd.fix) begin
      if (neg && (rem != 7'd0)) begin
        q_step <= ~{1'b0, dd};
        r_step <= {7'(cur_gap - rem), 1'b0};
      end else if (neg) begin
        q_step <= 34'(-{1'b0, dd});
        r_step <= '0;
      end else begin
        q_step <= {1'b0, dd};
        r_step <= {rem, 1'b0};
      end
    end
    if (cmd.emit) begin
      q_acc <= q_new;
      r_acc <= r_new;
      j <= j + 7'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.final_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value <= q_new[31:0];
      interpolated <= 1'b1;
      restart_active <= act;
      last_of_run <= 1'b0;
    end else if (cmd.final_ld) begin
      out_value <= cur_value;
      interpolated <= 1'b0;
      restart_active <= act;
      last_of_run <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* src/sgi_ctrl.sv */
// controller: sequences accept, divide, interpolation and final result
`timescale 1ns / 1ps
`default_nettype none

module sgi_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sgi_pkg::sts_t sts,
  output sgi_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_FIX   = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = sts.needs_fill ? S_DIV : S_FINAL;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_next = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.final_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* src/sample_gap_interpolator.sv */
// top level of the sample gap interpolator
//
// Takes one sample and its gap per input transaction and returns one result
// transaction per output sample from a registered output. A restart item or a
// contiguous item (gap 0 or 1) goes from the accept state straight to the
// state that loads the result. An item with a gap g from 2 to the clamped
// max_gap first runs a bit-serial divide of the sample difference by g (one
// quotient bit per cycle) and a correction step, then emits one interpolated
// sample per cycle while the output is taken, and the new sample last.
// Output back pressure stalls the emits and the final load. Input is accepted
// only between items; configuration writes take effect at once and belong
// between items.
`timescale 1ns / 1ps
`default_nettype none

module sample_gap_interpolator (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] sample_value,
  input  wire logic [15:0]        gap,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_value,
  output logic                    interpolated,
  output logic                    restart_active,
  output logic                    last_of_run
);

  sgi_pkg::cmd_t cmd;
  sgi_pkg::sts_t sts;

  // sequencing
  sgi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and state
  sgi_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_value   (sample_value),
    .gap            (gap),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_value      (out_value),
    .interpolated   (interpolated),
    .restart_active (restart_active),
    .last_of_run    (last_of_run)
  );

endmodule

`default_nettype wire

/* src/sgi_checker.sv */
// port-level checks for the sample gap interpolator and their binding
`timescale 1ns / 1ps
`default_nettype none

module sgi_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value,
  input wire logic        interpolated,
  input wire logic        last_of_run
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transaction");

  // a synthesized sample is never the last of its run
  a_interp_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && interpolated) |-> !last_of_run)
    else $error("interpolated result marked last of run");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
    else $error("stalled result changed");

endmodule

bind sample_gap_interpolator sgi_checker u_sgi_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_value    (out_value),
  .interpolated (interpolated),
  .last_of_run  (last_of_run)
);

`default_nettype wire

/* tb/tb_sample_gap_interpolator.sv */
// self-checking testbench for the sample gap interpolator
`timescale 1ns / 1ps

module tb_sample_gap_interpolator;

  localparam int STALL_LIMIT = 3000;
  localparam int ERROR_PRINT_CAP = 40;

  // one result transaction as the block should produce it
  typedef struct packed {
    logic signed [31:0] value;
    logic               is_fill;
    logic               in_restart;
    logic               run_end;
  } gap_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = sgi_pkg::REG_MAX_GAP;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] sample_value = '0;
  logic [15:0]        gap = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_value;
  logic               interpolated;
  logic               restart_active;
  logic               last_of_run;

  // shadow of the block state and registers
  logic [6:0]         shadow_max_gap = sgi_pkg::MAX_GAP_RESET;
  logic [15:0]        shadow_restart_len = sgi_pkg::RESTART_LENGTH_RESET;
  logic signed [31:0] shadow_last = '0;
  logic [15:0]        shadow_count = '0;
  logic               shadow_seen = 1'b0;

  gap_result_t        pending_results[$];
  gap_result_t        want;

  // traffic shaping knobs
  bit                 sender_idles = 1'b1;
  bit                 receiver_stalls = 1'b1;
  int                 burst_left = 0;
  int                 hold_run = 0;
  int                 pass_run = 0;

  int                 errors = 0;
  int                 items_sent = 0;
  int                 results_checked = 0;
  int                 fills_checked = 0;
  int                 restarts_seen = 0;
  int                 quiet_cycles = 0;

  sample_gap_interpolator uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample_value   (sample_value),
    .gap            (gap),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .interpolated   (interpolated),
    .restart_active (restart_active),
    .last_of_run    (last_of_run)
  );

  always #5 clk = ~clk;

  // expected results for one accepted sample, state updated as the block does
  task automatic interpolate_sample(input logic signed [31:0] v, input logic [15:0] g);
    int          eff;
    bit          act;
    longint      gg;
    longint      prev;
    longint      diff;
    longint      num;
    longint      den;
    longint      quot;
    gap_result_t r;
    eff = (shadow_max_gap > sgi_pkg::MAX_GAP_LIMIT) ? sgi_pkg::MAX_GAP_LIMIT
                                                     : int'(shadow_max_gap);
    if (!shadow_seen || int'(g) > eff) begin
      shadow_seen = 1'b1;
      shadow_count = 16'd1;
      shadow_last = v;
      r = '{value: v, is_fill: 1'b0, in_restart: 1'b1, run_end: 1'b1};
      pending_results.push_back(r);
      restarts_seen++;
      return;
    end
    act = shadow_count < shadow_restart_len;
    if (act && shadow_count != 16'hFFFF) shadow_count = shadow_count + 16'd1;
    gg = longint'(g);
    prev = longint'(shadow_last);
    diff = longint'(v) - prev;
    den = 2 * gg;
    for (longint j = 1; j < gg; j++) begin
      num = 2 * (prev * gg + j * diff) + gg;
      quot = num / den;
      // floor rather than truncation for negative quotients
      if ((num % den) != 0 && num < 0) quot = quot - 1;
      r = '{value: quot[31:0], is_fill: 1'b1, in_restart: act, run_end: 1'b0};
      pending_results.push_back(r);
    end
    r = '{value: v, is_fill: 1'b0, in_restart: act, run_end: 1'b1};
    pending_results.push_back(r);
    shadow_last = v;
  endtask

  // present one sample and hold it until taken, then maybe pause
  task automatic send_sample(input logic signed [31:0] v, input logic [15:0] g);
    in_valid <= 1'b1;
    sample_value <= v;
    gap <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    interpolate_sample(v, g);
    items_sent++;
    if (sender_idles) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(0, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  // stop sending and wait until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, only called while the block is idle
  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sgi_pkg::REG_MAX_GAP) shadow_max_gap = val[6:0];
    else shadow_restart_len = val;
    @(posedge clk);
  endtask

  // reset values, first sample, contiguous, fills, boundary and value extremes
  task automatic test_default_registers();
    send_sample(32'sd100, 16'd0);
    send_sample(32'sd104, 16'd1);
    send_sample(32'sd110, 16'd0);
    send_sample(32'sd120, 16'd2);
    send_sample(-32'sd7, 16'd10);
    send_sample(-32'sd8, 16'd11);
    send_sample(32'sh7FFF_FFFF, 16'd3);
    send_sample(32'sh8000_0000, 16'd10);
    send_sample(32'sh7FFF_FFFF, 16'd7);
    send_sample(-32'sd1, 16'hFFFF);
    send_sample(-32'sd4, 16'd2);
    send_sample(32'sd5, 16'd3);
  endtask

  // max_gap of zero and a value above the clamp
  task automatic test_max_gap_extremes();
    drain_results();
    write_reg(sgi_pkg::REG_MAX_GAP, 16'd0);
    send_sample(32'sd1, 16'd0);
    send_sample(32'sd2, 16'd1);
    send_sample(32'sd3, 16'd0);
    drain_results();
    write_reg(sgi_pkg::REG_MAX_GAP, 16'd127);
    send_sample(-32'sd1000, 16'd64);
    send_sample(32'sd640, 16'd65);
  endtask

  // flag clearing right after a restart and after a short count
  task automatic test_restart_length_extremes();
    drain_results();
    write_reg(sgi_pkg::REG_RESTART_LENGTH, 16'd0);
    send_sample(32'sd5, 16'd0);
    send_sample(32'sd9, 16'd2);
    drain_results();
    write_reg(sgi_pkg::REG_RESTART_LENGTH, 16'd2);
    send_sample(-32'sd50, 16'd100);
    send_sample(-32'sd51, 16'd0);
    send_sample(-32'sd52, 16'd1);
  endtask

  // random samples and gaps under one register setting
  task automatic run_random_phase(input logic [6:0] mg, input logic [15:0] rl,
                                  input int count, input bit idles, input bit stalls);
    int                 eff;
    int                 cap;
    int                 pick;
    logic [15:0]        g;
    logic signed [31:0] v;
    drain_results();
    write_reg(sgi_pkg::REG_MAX_GAP, {9'd0, mg});
    write_reg(sgi_pkg::REG_RESTART_LENGTH, rl);
    sender_idles = idles;
    receiver_stalls = stalls;
    eff = (mg > sgi_pkg::MAX_GAP_LIMIT) ? sgi_pkg::MAX_GAP_LIMIT : int'(mg);
    cap = (eff < 8) ? eff : 8;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) g = 16'($urandom_range(0, 1));
      else if (pick < 75 && eff >= 2) g = 16'($urandom_range(2, cap));
      else if (pick < 85 && eff >= 2) g = 16'($urandom_range(2, eff));
      else if (pick < 93) g = 16'(eff + $urandom_range(0, 2));
      else g = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 50) v = shadow_last + 32'($urandom_range(0, 2000)) - 32'sd1000;
      else if (pick < 80) v = $urandom;
      else if (pick < 90) begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end else v = 32'($urandom_range(0, 255)) - 32'sd128;
      send_sample(v, g);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(7'($urandom_range(4, 16)), 16'($urandom_range(0, 30)), 80, 1'b1, 1'b1);
    run_random_phase(7'd64, 16'd0, 80, 1'b0, 1'b0);
    run_random_phase(7'd1, 16'hFFFF, 80, 1'b1, 1'b1);
    run_random_phase(7'($urandom_range(2, 64)), 16'($urandom_range(1, 50)), 80, 1'b1, 1'b1);
  endtask

  // receiver: ready runs broken by stalls of random length
  always @(posedge clk) begin
    if (!receiver_stalls) begin
      out_ready <= 1'b1;
    end else if (hold_run > 0) begin
      out_ready <= 1'b0;
      hold_run--;
    end else if (pass_run > 0) begin
      out_ready <= 1'b1;
      pass_run--;
    end else begin
      out_ready <= 1'b1;
      pass_run = $urandom_range(0, 9);
      hold_run = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 4);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
    errors++;
    if (errors <= ERROR_PRINT_CAP)
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, what,
               $signed(exp_val), $signed(act_val));
  endtask

  // compare each output transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= ERROR_PRINT_CAP)
          $display("%0t ns: unexpected result, expected none actual value %0d", $time,
                   out_value);
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value) report_mismatch("out_value", want.value, out_value);
        if (interpolated !== want.is_fill)
          report_mismatch("interpolated", 32'(want.is_fill), 32'(interpolated));
        if (restart_active !== want.in_restart)
          report_mismatch("restart_active", 32'(want.in_restart), 32'(restart_active));
        if (last_of_run !== want.run_end)
          report_mismatch("last_of_run", 32'(want.run_end), 32'(last_of_run));
        results_checked++;
        if (want.is_fill) fills_checked++;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_registers();
    test_max_gap_extremes();
    test_restart_length_extremes();
    test_random_traffic();
    drain_results();
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t ns: %0d expected results never arrived", $time, pending_results.size());
    end
    $display("Sent %0d samples, checked %0d results (%0d gap fills, %0d restarts)",
             items_sent, results_checked, fills_checked, restarts_seen);
    $display("Register settings covered max_gap 0, 1, 64, 127 and restart_length 0 to 65535");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
